/* rtl/sm3_pkg.sv */
// SM3 compression package: word and state types, initial value, round
// constants, control bundles and the rotate/permute helpers.
// No dependencies.
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] state_t;

  // Index 0 is word A of the initial value.
  localparam state_t IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_LEN  = 8;

  typedef struct packed {
    logic push;
    logic step;
  } sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] round;
  } round_ctrl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    word_t r;
    r = (x << n) | (x >> (32 - n));
    return r;
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

endpackage

/* rtl/sm3_if.sv */
// Valid/ready channel interfaces for the SM3 compression block.
// Depends on sm3_pkg for the word type.
interface sm3_in_if;
  logic              valid;
  logic              ready;
  sm3_pkg::word_t    message_word;
  logic              first_block;
  logic              final_block;

  modport source (output valid, output message_word, output first_block,
                  output final_block, input ready);
  modport sink (input valid, input message_word, input first_block,
                input final_block, output ready);
endinterface

interface sm3_out_if;
  logic              valid;
  logic              ready;
  sm3_pkg::word_t    digest_word;
  logic              digest_last;

  modport source (output valid, output digest_word, output digest_last,
                  input ready);
  modport sink (input valid, input digest_word, input digest_last,
                output ready);
endinterface

/* rtl/sm3_sched.sv */
// Message schedule: a 16-word sliding window that takes the block words
// and then produces W[j] and W'[j] one round at a time. Depends on sm3_pkg.
module sm3_sched (
  input  logic                  clk_i,
  input  sm3_pkg::sched_ctrl_t  ctrl_i,
  input  sm3_pkg::word_t        data_i,
  output sm3_pkg::word_t        w_o,
  output sm3_pkg::word_t        wp_o
);

  sm3_pkg::word_t win_q [sm3_pkg::BLOCK_WORDS];
  sm3_pkg::word_t w_new;
  sm3_pkg::word_t shift_in;

  // Window holds W[j..j+15]; next word is W[j+16].
  assign w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl(win_q[13], 15))
               ^ sm3_pkg::rotl(win_q[3], 7) ^ win_q[10];
  assign shift_in = ctrl_i.push ? data_i : w_new;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < sm3_pkg::BLOCK_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sm3_pkg::BLOCK_WORDS-1] <= shift_in;
    end
  end

  assign w_o  = win_q[0];
  assign wp_o = win_q[0] ^ win_q[4];

endmodule

/* rtl/sm3_round.sv */
// Shared SM3 round unit: working registers A..H and the rotating round
// constant, advanced one round per step. Depends on sm3_pkg.
module sm3_round (
  input  logic                  clk_i,
  input  sm3_pkg::round_ctrl_t  ctrl_i,
  input  sm3_pkg::state_t       cv_i,
  input  sm3_pkg::word_t        w_i,
  input  sm3_pkg::word_t        wp_i,
  output sm3_pkg::state_t       v_o
);

  sm3_pkg::state_t v_q, v_d;
  sm3_pkg::word_t  t_q, t_d;
  sm3_pkg::word_t  a12, ss1, ss2, ff, gg, tt1, tt2;
  logic            early;

  assign early = (ctrl_i.round < 6'd16);

  always_comb begin
    a12 = sm3_pkg::rotl(v_q[0], 12);
    ss1 = sm3_pkg::rotl(a12 + v_q[4] + t_q, 7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
    tt1 = ff + v_q[3] + ss2 + wp_i;
    tt2 = gg + v_q[7] + ss1 + w_i;
    v_d[0] = tt1;
    v_d[1] = v_q[0];
    v_d[2] = sm3_pkg::rotl(v_q[1], 9);
    v_d[3] = v_q[2];
    v_d[4] = sm3_pkg::perm0(tt2);
    v_d[5] = v_q[4];
    v_d[6] = sm3_pkg::rotl(v_q[5], 19);
    v_d[7] = v_q[6];
    // Constant for round j is T rotated by j mod 32; switch T at round 16.
    t_d = (ctrl_i.round == 6'd15) ? sm3_pkg::rotl(sm3_pkg::T_HIGH, 16)
                                  : sm3_pkg::rotl(t_q, 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= cv_i;
      t_q <= sm3_pkg::T_LOW;
    end else if (ctrl_i.step) begin
      v_q <= v_d;
      t_q <= t_d;
    end
  end

  assign v_o = v_q;

endmodule

/* rtl/sm3_compression.sv */
// SM3 compression top level: sequencer, chaining value and digest output.
// Depends on sm3_pkg, sm3_if, sm3_sched and sm3_round.
//
// Sixteen message words are taken one per cycle while the source holds valid;
// the sixteenth starts the compression, which runs 64 rounds through a single
// round unit at one round per cycle, then folds into the chaining value.
// Input is not ready from the last word of a block until the fold is done;
// a final block then presents eight digest words, one per cycle when the
// sink is ready, with input held off until the eighth beat is taken.
// After reset the chaining value is the SM3 initial value.
module sm3_compression (
  input  logic             clk_i,
  input  logic             rst_ni,
  sm3_in_if.sink           in_if,
  sm3_out_if.source        out_if
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FOLD  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [3:0]           word_idx_q, word_idx_d;
  logic [5:0]           round_q, round_d;
  logic [2:0]           emit_q, emit_d;
  logic                 final_q, final_d;
  sm3_pkg::state_t      cv_q, cv_d;
  sm3_pkg::state_t      v;
  sm3_pkg::word_t       w, wp;
  sm3_pkg::sched_ctrl_t sched_ctrl;
  sm3_pkg::round_ctrl_t round_ctrl;
  logic                 in_beat, out_beat;

  assign in_if.ready  = (state_q == S_LOAD);
  assign in_beat      = in_if.valid && in_if.ready;
  assign out_if.valid = (state_q == S_EMIT);
  assign out_beat     = out_if.valid && out_if.ready;
  assign out_if.digest_word = cv_q[emit_q];
  assign out_if.digest_last = (emit_q == 3'(sm3_pkg::DIGEST_LEN - 1));

  always_comb begin
    state_d    = state_q;
    word_idx_d = word_idx_q;
    round_d    = round_q;
    emit_d     = emit_q;
    final_d    = final_q;
    cv_d       = cv_q;
    sched_ctrl = '0;
    round_ctrl = '0;
    round_ctrl.round = round_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_beat) begin
          sched_ctrl.push = 1'b1;
          word_idx_d = word_idx_q + 4'd1;
          if (word_idx_q == 4'd0 && in_if.first_block) begin
            cv_d = sm3_pkg::IV;
          end
          if (word_idx_q == 4'(sm3_pkg::BLOCK_WORDS - 1)) begin
            // Load A..H from the chaining value; a reload on word zero is
            // already in cv_q by now.
            round_ctrl.load = 1'b1;
            final_d = in_if.final_block;
            round_d = '0;
            state_d = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        sched_ctrl.step = 1'b1;
        round_ctrl.step = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'(sm3_pkg::ROUNDS - 1)) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cv_d    = cv_q ^ v;
        emit_d  = '0;
        state_d = final_q ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (out_beat) begin
          emit_d = emit_q + 3'd1;
          if (out_if.digest_last) begin
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      word_idx_q <= '0;
      round_q    <= '0;
      emit_q     <= '0;
      final_q    <= 1'b0;
      cv_q       <= sm3_pkg::IV;
    end else begin
      state_q    <= state_d;
      word_idx_q <= word_idx_d;
      round_q    <= round_d;
      emit_q     <= emit_d;
      final_q    <= final_d;
      cv_q       <= cv_d;
    end
  end

  sm3_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .data_i (in_if.message_word),
    .w_o    (w),
    .wp_o   (wp)
  );

  sm3_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .cv_i   (cv_q),
    .w_i    (w),
    .wp_i   (wp),
    .v_o    (v)
  );

endmodule

/* rtl/sm3_checker.sv */
// Port-level checks for sm3_compression, attached by the bind below.
// Depends on sm3_compression's channel ports only.
module sm3_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic [31:0]    digest_word_i,
  input logic           digest_last_i
);

  // No new words are taken while a digest is being delivered.
  a_no_input_during_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while digest pending");

  // A digest follows the compression, never a word beat directly.
  a_digest_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("digest started without compression");

  // Digest words run back to back until the last one.
  a_digest_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !digest_last_i) |=> out_valid_i)
    else $error("digest ended early");

  // Hold a stalled digest beat.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(digest_word_i) && $stable(digest_last_i)))
    else $error("stalled digest beat changed");

endmodule

bind sm3_compression sm3_checker u_sm3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .digest_word_i (out_if.digest_word),
  .digest_last_i (out_if.digest_last)
);

/* tb/sm3_compression_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sm3_compression: drives random message blocks
// and compares each digest beat with a built-in SM3 model of the block.
// Depends on sm3_pkg, sm3_if and the sm3_compression RTL.
module sm3_compression_tb;

  localparam int unsigned HOLD_CYCLES = 300;
  // Longest quiet stretch: hold-off plus one compression and stalls, with margin.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 100;

  typedef struct packed {
    sm3_pkg::word_t dword;
    logic           is_last;
  } digest_beat_t;

  logic clk_i;
  logic rst_ni;

  sm3_in_if  in_ch ();
  sm3_out_if out_ch ();

  sm3_compression u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Model state: chaining value, current block and word position.
  sm3_pkg::state_t chain_v;
  sm3_pkg::word_t  msg_buf [16];
  logic [3:0]      msg_pos;
  digest_beat_t    expected_digest_q [$];

  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned blocks_sent;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sm3_pkg::word_t rotate_left(input sm3_pkg::word_t v,
                                                 input int unsigned sh);
    logic [63:0] dbl;
    dbl = {v, v} << (sh % 32);
    return dbl[63:32];
  endfunction

  task automatic sm3_compress_into_chain();
    sm3_pkg::word_t w [68];
    sm3_pkg::word_t wx [64];
    sm3_pkg::word_t a, b, c, d, e, f, g, h;
    sm3_pkg::word_t a12, ss1, ss2, ff, gg, tt1, tt2, tj, x;
    for (int j = 0; j < 16; j++) w[j] = msg_buf[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rotate_left(w[j-3], 15);
      w[j] = x ^ rotate_left(x, 15) ^ rotate_left(x, 23) ^ rotate_left(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 64; j++) wx[j] = w[j] ^ w[j+4];
    {h, g, f, e, d, c, b, a} = chain_v;
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = rotate_left(a, 12);
      x   = a12 + e + rotate_left(tj, j);
      ss1 = rotate_left(x, 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + wx[j];
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rotate_left(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rotate_left(f, 19);
      f = e;
      e = tt2 ^ rotate_left(tt2, 9) ^ rotate_left(tt2, 17);
    end
    chain_v = chain_v ^ {h, g, f, e, d, c, b, a};
  endtask

  // Advance the model by one accepted word; queue the digest on a final block.
  task automatic sm3_absorb_word(input sm3_pkg::word_t w, input logic first_flag,
                                 input logic last_flag);
    if (msg_pos == 4'd0 && first_flag) chain_v = sm3_pkg::IV;
    msg_buf[msg_pos] = w;
    if (msg_pos == 4'd15) begin
      sm3_compress_into_chain();
      if (last_flag) begin
        for (int k = 0; k < 8; k++) begin
          expected_digest_q.push_back('{dword: chain_v[k], is_last: (k == 7)});
        end
      end
    end
    msg_pos = msg_pos + 4'd1;
  endtask

  task automatic send_word(input sm3_pkg::word_t w, input logic first_flag,
                           input logic last_flag);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid        <= 1'b0;
      in_ch.message_word <= $urandom();
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.first_block  <= first_flag;
    in_ch.final_block  <= last_flag;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    sm3_absorb_word(w, first_flag, last_flag);
  endtask

  function automatic sm3_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sm3_pkg::word_t'(1) << $urandom_range(0, 31);
      3:       return ~(sm3_pkg::word_t'(1) << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Flags off their active word are ignored; with noisy set, randomize them.
  task automatic send_block(input logic first_flag, input logic last_flag, input bit noisy);
    logic fb, lb;
    for (int i = 0; i < 16; i++) begin
      fb = (i == 0)  ? first_flag : (noisy ? logic'($urandom_range(0, 1)) : 1'b0);
      lb = (i == 15) ? last_flag  : (noisy ? logic'($urandom_range(0, 1)) : 1'b0);
      send_word(pick_word(), fb, lb);
    end
    blocks_sent++;
  endtask

  task automatic send_message(input int unsigned n_blocks);
    for (int unsigned b = 0; b < n_blocks; b++) begin
      send_block(b == 0, b == n_blocks - 1, $urandom_range(0, 1));
    end
  endtask

  task automatic send_random_traffic(input int unsigned n_blocks);
    int unsigned start;
    start = blocks_sent;
    while (blocks_sent - start < n_blocks) begin
      if ($urandom_range(0, 3) == 0) begin
        send_block($urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
      end else begin
        send_message($urandom_range(1, 3));
      end
    end
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_digest_q.size() != 0);
  endtask

  // After reset without a first flag: all-ones block, stray flags on every word,
  // chained into an all-zeros final block, stray first flags; all must be ignored.
  task automatic test_directed_edges();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < 16; i++) begin
      send_word('1, (i != 0), (i != 15));
    end
    for (int i = 0; i < 16; i++) begin
      send_word('0, (i != 0), (i == 15));
    end
  endtask

  task automatic test_random_messages();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_random_traffic(8);
  endtask

  // Hold the sink off while final blocks keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    send_block(1'b1, 1'b1, 1'b0);
    send_block(1'b1, 1'b1, 1'b1);
    wait (!hold_req);
  endtask

  // Drain all digests, then continue the chain without reloading the IV.
  task automatic test_drain_pause();
    send_message(1);
    pause_until_drained();
    send_block(1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_steady_stream();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random_traffic(4);
  endtask

  initial begin : run_tests
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.message_word = '0;
    in_ch.first_block  = 1'b0;
    in_ch.final_block  = 1'b0;
    chain_v            = sm3_pkg::IV;
    msg_pos            = 4'd0;
    err_cnt            = 0;
    blocks_sent        = 0;
    src_idle_en        = 1'b0;
    sink_idle_en       = 1'b0;
    hold_req           = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_edges();
    test_random_messages();
    test_output_backpressure();
    test_drain_pause();
    test_steady_stream();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Sink ready: long hold-off on request, otherwise random stall bursts.
  initial begin : sink_side
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        if (hold_left == 0) hold_left = HOLD_CYCLES;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : digest_check
    digest_beat_t exp_beat;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat: expected none, actual word %08h last %0b",
                 $time, out_ch.digest_word, out_ch.digest_last);
        err_cnt++;
      end else begin
        exp_beat = expected_digest_q.pop_front();
        if (out_ch.digest_word !== exp_beat.dword) begin
          $display("%0t: digest_word mismatch: expected %08h, actual %08h",
                   $time, exp_beat.dword, out_ch.digest_word);
          err_cnt++;
        end
        if (out_ch.digest_last !== exp_beat.is_last) begin
          $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                   $time, exp_beat.is_last, out_ch.digest_last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
